// ----- rtl/mstg_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the multitone generator.
`timescale 1ns / 1ps

package mstg_pkg;

  localparam int MAX_CHANNELS   = 8;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int NUM_TONES      = 3;

  localparam int CHAN_BITS   = $clog2(MAX_CHANNELS);
  localparam int COUNT_BITS  = 4;
  localparam int CFG_BITS    = 32;
  localparam int INDEX_BITS  = 2;

  // Sine magnitude: 16383 needs 14 bits, signed sine 15, sum of three 17
  localparam int AMP_BITS    = 14;
  localparam int SINE_BITS   = AMP_BITS + 1;
  localparam int SAMPLE_BITS = 17;

  localparam int QTR_BITS  = SINE_ADDR_BITS - 2;
  localparam int QTR_DEPTH = 2 ** QTR_BITS;

  // Angle of one quarter-table step, in radians
  localparam real QTR_ANGLE = 1.5707963267948966 / real'(QTR_DEPTH);

  localparam logic [AMP_BITS-1:0] SINE_AMP = AMP_BITS'(16383);

  localparam logic [COUNT_BITS-1:0] CHANNEL_COUNT_RST = COUNT_BITS'(4);
  localparam logic [PHASE_BITS-1:0] TONE_A_STEP_RST   = PHASE_BITS'(32'd16421587);
  localparam logic [PHASE_BITS-1:0] TONE_B_STEP_RST   = PHASE_BITS'(32'd6007898);
  localparam logic [PHASE_BITS-1:0] TONE_C_STEP_RST   = PHASE_BITS'(32'd90518994);

  // Configuration register indexes
  typedef enum logic [INDEX_BITS-1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_TONE_A_STEP   = 2'd1,
    REG_TONE_B_STEP   = 2'd2,
    REG_TONE_C_STEP   = 2'd3
  } cfg_reg_t;

  // One tick of work handed from the front to the back
  typedef struct packed {
    logic [NUM_TONES-1:0][PHASE_BITS-1:0] phase;
    logic [COUNT_BITS-1:0]                count;
  } tick_job_t;

  typedef logic [AMP_BITS-1:0] sine_qtr_t [QTR_DEPTH];

  // Build round(16383*sin(pi/2*m/QTR_DEPTH)) for m in 0..QTR_DEPTH-1
  function automatic sine_qtr_t sine_qtr_init();
    sine_qtr_t tbl;
    real       ang;
    real       val;
    for (int m = 0; m < QTR_DEPTH; m++) begin
      ang    = QTR_ANGLE * real'(m);
      val    = 16383.0 * $sin(ang) + 0.5;
      tbl[m] = AMP_BITS'($rtoi(val));
    end
    return tbl;
  endfunction

  localparam sine_qtr_t SINE_QTR = sine_qtr_init();

  // Full-wave sine from the quarter table by symmetry
  function automatic logic signed [SINE_BITS-1:0] sine_lookup(
    input logic [SINE_ADDR_BITS-1:0] k
  );
    logic [1:0]          q;
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS:0]   m;
    logic [AMP_BITS-1:0] mag;
    q   = k[SINE_ADDR_BITS-1 -: 2];
    r   = k[QTR_BITS-1:0];
    m   = q[0] ? ((QTR_BITS+1)'(QTR_DEPTH) - {1'b0, r}) : {1'b0, r};
    mag = m[QTR_BITS] ? SINE_AMP : SINE_QTR[m[QTR_BITS-1:0]];
    return q[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

endpackage

// ----- rtl/mstg_front.sv -----
// Front end: configuration registers, tone phase accumulators and tick classification.
`timescale 1ns / 1ps

module mstg_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mstg_pkg::INDEX_BITS-1:0]     cfg_index,
  input  logic [mstg_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  logic                                restart,
  input  logic                                q_full,
  output logic                                q_push,
  output mstg_pkg::tick_job_t                 q_data
);

  logic [mstg_pkg::COUNT_BITS-1:0] channel_count;
  logic [mstg_pkg::PHASE_BITS-1:0] step  [mstg_pkg::NUM_TONES];
  logic [mstg_pkg::PHASE_BITS-1:0] phase [mstg_pkg::NUM_TONES];

  logic [mstg_pkg::PHASE_BITS-1:0] base  [mstg_pkg::NUM_TONES];
  logic [mstg_pkg::COUNT_BITS-1:0] count_sat;
  logic                            accept;

  assign cfg_ready  = 1'b1;
  assign tick_ready = !q_full;
  assign accept     = tick_valid && tick_ready;

  // Saturate the channel count at the channel limit
  assign count_sat = (channel_count > mstg_pkg::COUNT_BITS'(mstg_pkg::MAX_CHANNELS)) ?
                     mstg_pkg::COUNT_BITS'(mstg_pkg::MAX_CHANNELS) : channel_count;

  // Phases used for this tick, zeroed on restart
  always_comb begin
    for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
      base[t] = restart ? '0 : phase[t];
    end
  end

  // Drop ticks that emit no channel; they still advance the phases
  always_comb begin
    q_push       = accept && (count_sat != '0);
    q_data.count = count_sat;
    for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
      q_data.phase[t] = base[t];
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= mstg_pkg::CHANNEL_COUNT_RST;
      step[0]       <= mstg_pkg::TONE_A_STEP_RST;
      step[1]       <= mstg_pkg::TONE_B_STEP_RST;
      step[2]       <= mstg_pkg::TONE_C_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mstg_pkg::cfg_reg_t'(cfg_index))
        mstg_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[mstg_pkg::COUNT_BITS-1:0];
        mstg_pkg::REG_TONE_A_STEP:   step[0] <= cfg_data[mstg_pkg::PHASE_BITS-1:0];
        mstg_pkg::REG_TONE_B_STEP:   step[1] <= cfg_data[mstg_pkg::PHASE_BITS-1:0];
        mstg_pkg::REG_TONE_C_STEP:   step[2] <= cfg_data[mstg_pkg::PHASE_BITS-1:0];
      endcase
    end
  end

  // Advance tone phases once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
        phase[t] <= '0;
      end
    end else if (accept) begin
      for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
        phase[t] <= base[t] + step[t];
      end
    end
  end

endmodule

// ----- rtl/mstg_queue.sv -----
// Two-entry job queue between the front end and the channel sequencer.
`timescale 1ns / 1ps

module mstg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mstg_pkg::tick_job_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output mstg_pkg::tick_job_t pop_data
);

  mstg_pkg::tick_job_t entry [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;
  logic                do_push;
  logic                do_pop;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/mstg_back.sv -----
// Back end: per-channel phase sequencer, sine lookup and summing pipeline.
`timescale 1ns / 1ps

module mstg_back (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      job_valid,
  input  mstg_pkg::tick_job_t                       job,
  output logic                                      job_pop,
  output logic                                      smp_valid,
  input  logic                                      smp_ready,
  output logic [mstg_pkg::CHAN_BITS-1:0]            channel,
  output logic signed [mstg_pkg::SAMPLE_BITS-1:0]   sample_value,
  output logic                                      last
);

  localparam int TOP = mstg_pkg::PHASE_BITS - 1;
  localparam int LOW = mstg_pkg::PHASE_BITS - mstg_pkg::SINE_ADDR_BITS;

  // Sequencer state
  logic                                           busy;
  logic [mstg_pkg::CHAN_BITS-1:0]                 chan;
  logic [mstg_pkg::COUNT_BITS-1:0]                cnt;
  logic [mstg_pkg::PHASE_BITS-1:0]                acc  [mstg_pkg::NUM_TONES];
  logic [mstg_pkg::PHASE_BITS-1:0]                base [mstg_pkg::NUM_TONES];

  // Address stage
  logic                                           s1_valid;
  logic [mstg_pkg::SINE_ADDR_BITS-1:0]            s1_addr [mstg_pkg::NUM_TONES];
  logic [mstg_pkg::CHAN_BITS-1:0]                 s1_chan;
  logic                                           s1_last;

  // Sine stage
  logic                                           s2_valid;
  logic signed [mstg_pkg::SINE_BITS-1:0]          s2_sine [mstg_pkg::NUM_TONES];
  logic [mstg_pkg::CHAN_BITS-1:0]                 s2_chan;
  logic                                           s2_last;

  logic                                           en;
  logic                                           issue_last;
  logic                                           load;
  logic signed [mstg_pkg::SAMPLE_BITS-1:0]        sum;

  // Whole pipeline moves when the output register is free
  assign en         = !smp_valid || smp_ready;
  assign issue_last = busy && ((mstg_pkg::COUNT_BITS'(chan) + 1'b1) == cnt);
  assign load       = en && job_valid && (!busy || issue_last);
  assign job_pop    = load;

  assign sum = mstg_pkg::SAMPLE_BITS'(s2_sine[0]) + mstg_pkg::SAMPLE_BITS'(s2_sine[1]) +
               mstg_pkg::SAMPLE_BITS'(s2_sine[2]);

  // Step through channels; channel c+1 phase is channel c phase plus the tone phase
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (en) begin
      if (load) begin
        busy <= 1'b1;
      end else if (issue_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (load) begin
        chan <= '0;
        cnt  <= job.count;
        for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
          acc[t]  <= job.phase[t];
          base[t] <= job.phase[t];
        end
      end else if (busy) begin
        chan <= chan + 1'b1;
        for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
          acc[t] <= acc[t] + base[t];
        end
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      smp_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= busy;
      s2_valid  <= s1_valid;
      smp_valid <= s2_valid;
    end
  end

  // Take sine addresses, look up sines, sum into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < mstg_pkg::NUM_TONES; t++) begin
        s1_addr[t] <= acc[t][TOP:LOW];
        s2_sine[t] <= mstg_pkg::sine_lookup(s1_addr[t]);
      end
      s1_chan      <= chan;
      s1_last      <= issue_last;
      s2_chan      <= s1_chan;
      s2_last      <= s1_last;
      channel      <= s2_chan;
      last         <= s2_last;
      sample_value <= sum;
    end
  end

endmodule

// ----- rtl/multitone_sine_test_generator.sv -----
// Top level of the three-tone multichannel sine test generator.
`timescale 1ns / 1ps

// Each accepted tick item produces one sample item per channel, channel 0 first, with
// last set on the final channel; channel c carries the sum of three sines at (c+1)
// times each tone phase. The back-end sequencer emits one sample per cycle while the
// output is not stalled, serving the N channels of a tick (channel_count, saturated at 8)
// before the next; a tick with a channel count of zero emits nothing and only advances
// the phases. Ticks are taken whenever the two-entry job queue has room, and the first
// sample of a tick passes the address, sine and output registers after the sequencer
// loads it. Configuration writes are always ready and take effect in the next cycle.
module multitone_sine_test_generator (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [mstg_pkg::INDEX_BITS-1:0]           cfg_index,
  input  logic [mstg_pkg::CFG_BITS-1:0]             cfg_data,
  input  logic                                      tick_valid,
  output logic                                      tick_ready,
  input  logic                                      restart,
  output logic                                      smp_valid,
  input  logic                                      smp_ready,
  output logic [mstg_pkg::CHAN_BITS-1:0]            channel,
  output logic signed [mstg_pkg::SAMPLE_BITS-1:0]   sample_value,
  output logic                                      last
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_not_empty;
  mstg_pkg::tick_job_t q_in;
  mstg_pkg::tick_job_t q_out;

  mstg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .restart    (restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  mstg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  mstg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_not_empty),
    .job          (q_out),
    .job_pop      (q_pop),
    .smp_valid    (smp_valid),
    .smp_ready    (smp_ready),
    .channel      (channel),
    .sample_value (sample_value),
    .last         (last)
  );

endmodule

// ----- verif/mstg_checker.sv -----
// Checker for the multitone generator: tracks config and tone phases, predicts and compares samples.
`timescale 1ns / 1ps

module mstg_checker
  import mstg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [INDEX_BITS-1:0]         cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          tick_valid,
  input  logic                          tick_ready,
  input  logic                          restart,
  input  logic                          smp_valid,
  input  logic                          smp_ready,
  input  logic [CHAN_BITS-1:0]          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last,
  output int                            mismatch_count,
  output int                            samples_owed
);

  localparam int SINE_DEPTH = 1 << SINE_ADDR_BITS;
  localparam int QUARTER    = SINE_DEPTH / 4;
  localparam real HALF_PI   = 1.5707963267948966;

  typedef struct {
    logic [CHAN_BITS-1:0]          chan;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_flag;
  } sample_t;

  sample_t               owed_q[$];
  int                    sine_rom [SINE_DEPTH];
  int                    errors = 0;
  logic [COUNT_BITS-1:0] chan_count;
  logic [PHASE_BITS-1:0] tone_step  [NUM_TONES];
  logic [PHASE_BITS-1:0] tone_phase [NUM_TONES];

  // Build the full sine wave: fold each address onto the first quarter, round half away
  initial begin : build_sine
    int  quad;
    int  fold;
    real mag;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      quad = k / QUARTER;
      fold = (quad % 2 == 1) ? QUARTER - (k % QUARTER) : k % QUARTER;
      mag  = $floor(16383.0 * $sin(HALF_PI * real'(fold) / real'(QUARTER)) + 0.5);
      sine_rom[k] = (quad >= 2) ? -$rtoi(mag) : $rtoi(mag);
    end
  end

  // Zero the phases on restart, queue one sample per channel for a tick, then advance the tone phases
  task automatic predict_tick(input logic zero_phases);
    int                    active;
    int                    sum;
    logic [PHASE_BITS-1:0] ph;
    sample_t               smp;
    active = (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_count);
    if (zero_phases) begin
      for (int t = 0; t < NUM_TONES; t++) tone_phase[t] = '0;
    end
    for (int c = 0; c < active; c++) begin
      sum = 0;
      for (int t = 0; t < NUM_TONES; t++) begin
        ph  = tone_phase[t] * PHASE_BITS'(c + 1);
        sum += sine_rom[ph[PHASE_BITS-1 -: SINE_ADDR_BITS]];
      end
      smp.chan      = CHAN_BITS'(c);
      smp.value     = SAMPLE_BITS'(sum);
      smp.last_flag = (c + 1 == active);
      owed_q.push_back(smp);
    end
    for (int t = 0; t < NUM_TONES; t++) tone_phase[t] = tone_phase[t] + tone_step[t];
  endtask

  // Compare an arriving sample with the oldest owed one
  task automatic check_sample();
    sample_t exp_smp;
    if (owed_q.size() == 0) begin
      if (errors < 10)
        $display("%0t: unexpected sample ch %0d val %0d last %0b",
                 $realtime, channel, sample_value, last);
      errors++;
    end else begin
      exp_smp = owed_q.pop_front();
      if (channel !== exp_smp.chan || sample_value !== exp_smp.value ||
          last !== exp_smp.last_flag) begin
        if (errors < 10)
          $display("%0t: sample mismatch: expected ch %0d val %0d last %0b, got ch %0d val %0d last %0b",
                   $realtime, exp_smp.chan, exp_smp.value, exp_smp.last_flag,
                   channel, sample_value, last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chan_count = CHANNEL_COUNT_RST;
      tone_step[0] = TONE_A_STEP_RST;
      tone_step[1] = TONE_B_STEP_RST;
      tone_step[2] = TONE_C_STEP_RST;
      for (int t = 0; t < NUM_TONES; t++) tone_phase[t] = '0;
      owed_q.delete();
    end else begin
      if (smp_valid && smp_ready) check_sample();
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CHANNEL_COUNT: chan_count   = cfg_data[COUNT_BITS-1:0];
          REG_TONE_A_STEP:   tone_step[0] = cfg_data[PHASE_BITS-1:0];
          REG_TONE_B_STEP:   tone_step[1] = cfg_data[PHASE_BITS-1:0];
          REG_TONE_C_STEP:   tone_step[2] = cfg_data[PHASE_BITS-1:0];
          default: ;
        endcase
      end
      if (tick_valid && tick_ready) predict_tick(restart);
    end
    mismatch_count <= errors;
    samples_owed   <= owed_q.size();
  end

endmodule

// ----- verif/multitone_sine_test_generator_test.sv -----
// Testbench top for the multitone generator: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module multitone_sine_test_generator_test;
  import mstg_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 25;

  logic                          clk;
  logic                          rst        = 1'b1;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [INDEX_BITS-1:0]         cfg_index  = '0;
  logic [CFG_BITS-1:0]           cfg_data   = '0;
  logic                          tick_valid = 1'b0;
  logic                          tick_ready;
  logic                          restart    = 1'b0;
  logic                          smp_valid;
  logic                          smp_ready  = 1'b0;
  logic [CHAN_BITS-1:0]          channel;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          last;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int mismatch_count;
  int samples_owed;

  multitone_sine_test_generator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .restart      (restart),
    .smp_valid    (smp_valid),
    .smp_ready    (smp_ready),
    .channel      (channel),
    .sample_value (sample_value),
    .last         (last)
  );

  mstg_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tick_valid     (tick_valid),
    .tick_ready     (tick_ready),
    .restart        (restart),
    .smp_valid      (smp_valid),
    .smp_ready      (smp_ready),
    .channel        (channel),
    .sample_value   (sample_value),
    .last           (last),
    .mismatch_count (mismatch_count),
    .samples_owed   (samples_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the sample side at random
  always @(negedge clk) begin
    smp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // End the run when no channel moves an item for too long
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (tick_valid && tick_ready) || (smp_valid && smp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold until every owed sample is out, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (samples_owed != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register; leaves cfg_valid high for a following write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [COUNT_BITS-1:0] count,
                           input logic [PHASE_BITS-1:0] step_a,
                           input logic [PHASE_BITS-1:0] step_b,
                           input logic [PHASE_BITS-1:0] step_c);
    logic [CFG_BITS-1:0] junk;
    junk = $urandom();
    wait_idle();
    // upper bits of the count write are don't-care, so fill them with noise
    write_reg(REG_CHANNEL_COUNT, {junk[CFG_BITS-1:COUNT_BITS], count});
    write_reg(REG_TONE_A_STEP, step_a);
    write_reg(REG_TONE_B_STEP, step_b);
    write_reg(REG_TONE_C_STEP, step_c);
    cfg_valid <= 1'b0;
  endtask

  // Send one tick item after a random gap; leaves tick_valid high
  task automatic send_tick(input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      restart    <= $urandom_range(1);
      @(negedge clk);
    end
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (!tick_ready);
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n, input int restart_pct);
    for (int i = 0; i < n; i++) send_tick($urandom_range(99) < restart_pct);
    tick_valid <= 1'b0;
  endtask

  function automatic logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COUNT_BITS'($urandom_range(15, MAX_CHANNELS + 1));
      default: return COUNT_BITS'($urandom_range(MAX_CHANNELS, 1));
    endcase
  endfunction

  function automatic logic [PHASE_BITS-1:0] pick_step();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(PHASE_BITS-1){1'b0}}};
      default: return PHASE_BITS'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration, with restarts at start and mid-run
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    tick_valid <= 1'b0;

    // All eight channels, extreme steps to force phase and multiple wrap
    configure(COUNT_BITS'(MAX_CHANNELS), '1, {1'b1, {(PHASE_BITS-1){1'b0}}}, PHASE_BITS'(1));
    send_tick(1'b1);
    run_ticks(3, 0);

    // Zero channels: nothing comes out, but phases keep moving
    configure('0, PHASE_BITS'(32'h1234_5678), '0, '1);
    send_tick(1'b0);
    send_tick(1'b1);
    tick_valid <= 1'b0;

    // Count above the maximum saturates
    configure('1, '0, PHASE_BITS'(32'h0040_0000), PHASE_BITS'(32'h7FFF_FFFF));
    run_ticks(2, 0);

    // Single channel
    configure(COUNT_BITS'(1), PHASE_BITS'(32'h0040_0000), '0, '1);
    send_tick(1'b1);
    send_tick(1'b0);
    tick_valid <= 1'b0;

    // Random phases, each with fresh settings and one of four idling modes in turn
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      configure(pick_count(), pick_step(), pick_step(), pick_step());
      run_ticks(TICKS_PER_PHASE, 10);
    end

    // Drain and decide
    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
